### sv/meeq_pkg.sv
package meeq_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int PIN_COUNT   = 32;

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int PIN_W  = 5;
  localparam int CODE_W = 7;
  localparam int MASK_W = 64;

  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);
  localparam logic [PIN_W:0]   PIN_LIMIT = (PIN_W + 1)'(PIN_COUNT);

  typedef enum logic [1:0] {
    OP_POST = 2'd0,
    OP_PEEK = 2'd1,
    OP_POP  = 2'd2,
    OP_NOP  = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t          opcode;
    logic [PIN_W-1:0] pin;
    logic             falling_edge;
  } item_t;

  typedef struct packed {
    logic [CODE_W-1:0] event_code;
    logic              found;
    logic              accepted;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             empty;
    logic             full;
  } status_t;

endpackage

### sv/meeq_if.sv
interface meeq_in_if;
  import meeq_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       opcode;
  logic [PIN_W-1:0] pin;
  logic             falling_edge;
  modport source (output valid, output opcode, output pin, output falling_edge, input ready);
  modport sink   (input valid, input opcode, input pin, input falling_edge, output ready);
endinterface

interface meeq_out_if;
  import meeq_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] event_code;
  logic              found;
  logic              accepted;
  modport source (output valid, output event_code, output found, output accepted, input ready);
  modport sink   (input valid, input event_code, input found, input accepted, output ready);
endinterface

interface meeq_cfg_if;
  import meeq_pkg::*;
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/meeq_in_reg.sv
module meeq_in_reg
  import meeq_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  item_t in_item,
  output logic  in_ready,
  input  logic  adv,
  output logic  valid_r,
  output item_t item_r
);

  // stage empties when its beat moves on
  assign in_ready = !valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

### sv/meeq_queue.sv
module meeq_queue
  import meeq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  item_t             item,
  input  logic [MASK_W-1:0] mask,
  output result_t           result,
  output status_t           status
);

  logic [CODE_W-1:0] store [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic              enabled;
  logic [PIN_W:0]    bit_idx;
  logic [CODE_W-1:0] new_code;
  logic              do_push;
  logic              do_pop;

  assign status.count = count_r;
  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == FULL_CNT);

  // falling enable at bit 2p, rising at 2p+1
  assign bit_idx  = {item.pin, !item.falling_edge};
  assign enabled  = ({1'b0, item.pin} < PIN_LIMIT) && mask[bit_idx];
  assign new_code = {item.pin, item.falling_edge ? 2'b01 : 2'b10};

  always_comb begin
    result  = '0;
    do_push = 1'b0;
    do_pop  = 1'b0;
    unique case (item.opcode)
      OP_POST: begin
        if (enabled && !status.full) begin
          result.accepted = 1'b1;
          do_push         = fire;
        end
      end
      OP_PEEK, OP_POP: begin
        if (!status.empty) begin
          result.event_code = store[rd_ptr_r];
          result.found      = 1'b1;
          do_pop            = fire && (item.opcode == OP_POP);
        end
      end
      default: begin
        result = '0;
      end
    endcase
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      count_nxt  = count_r + CNT_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      count_nxt  = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr_r] <= new_code;
    end
  end

endmodule

### sv/meeq_out_reg.sv
module meeq_out_reg
  import meeq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t result,
  input  logic    out_ready,
  output logic    adv_ok,
  output logic    out_valid_r,
  output result_t result_r
);

  assign adv_ok = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_ok) begin
      out_valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

endmodule

### sv/masked_edge_event_queue.sv
// masked edge event queue: posts pin edge events through a two-bit-per-pin enable
// mask (bit 2p falling, bit 2p+1 rising) into a four-entry ring, and answers peek
// and pop with the oldest event code ((pin << 2) | 1 falling, | 2 rising). every
// beat in gives exactly one result beat. a new beat is taken every clock unless
// the output stalls; each beat is held in the input register, then the result
// register, with the queue lookup and pointer update in between. a full queue or
// masked edge drops the post (accepted = 0); an empty queue gives found = 0, code
// 0. the mask register is written through the cfg channel, which is always ready.
module masked_edge_event_queue
  import meeq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  meeq_in_if.sink    in_ch,
  meeq_out_if.source out_ch,
  meeq_cfg_if.sink   cfg_ch
);

  logic [MASK_W-1:0] mask_r;

  item_t   in_item;
  item_t   item_r;
  logic    stage_valid_r;
  logic    adv_ok;
  logic    fire;
  result_t result;
  result_t result_r;
  status_t status;
  logic    out_valid_r;

  // mask register, cfg beats are always taken
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (cfg_ch.valid) begin
      mask_r <= cfg_ch.data;
    end
  end

  assign in_item.opcode       = opcode_t'(in_ch.opcode);
  assign in_item.pin          = in_ch.pin;
  assign in_item.falling_edge = in_ch.falling_edge;

  // item leaves the input register when the result register can take it
  assign fire = stage_valid_r && adv_ok;

  meeq_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_item  (in_item),
    .in_ready (in_ch.ready),
    .adv      (adv_ok),
    .valid_r  (stage_valid_r),
    .item_r   (item_r)
  );

  meeq_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item_r),
    .mask   (mask_r),
    .result (result),
    .status (status)
  );

  meeq_out_reg u_out_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (fire),
    .result      (result),
    .out_ready   (out_ch.ready),
    .adv_ok      (adv_ok),
    .out_valid_r (out_valid_r),
    .result_r    (result_r)
  );

  assign out_ch.valid      = out_valid_r;
  assign out_ch.event_code = result_r.event_code;
  assign out_ch.found      = result_r.found;
  assign out_ch.accepted   = result_r.accepted;

  // fill level never passes the ring depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    status.count <= FULL_CNT)
    else $error("event count above queue depth");

  // a post into a full ring must report a drop
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    fire && status.full && item_r.opcode == OP_POST |=> !out_ch.accepted)
    else $error("post accepted into full queue");

  // lookup on an empty ring must report not found
  a_empty_miss: assert property (@(posedge clk) disable iff (!rst_n)
    fire && status.empty && (item_r.opcode == OP_PEEK || item_r.opcode == OP_POP)
    |=> !out_ch.found && out_ch.event_code == '0)
    else $error("event found in empty queue");

  // a pop that hits removes exactly one entry
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !status.empty && item_r.opcode == OP_POP
    |=> status.count == $past(status.count) - CNT_W'(1))
    else $error("pop did not remove one entry");

endmodule
